@@ rtl/self_organizing_list_unit_macros.svh @@
// Assertion macros for the self-organizing list unit checker.
// Each macro builds one labeled concurrent assertion clocked on the rising edge.
`ifndef SELF_ORGANIZING_LIST_UNIT_MACROS_SVH
`define SELF_ORGANIZING_LIST_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SOL_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SOL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sol_pkg.sv @@
// Shared types and constants for the self-organizing list unit.
// Used by every module of the block; depends on nothing else.
package sol_pkg;

	localparam int DEPTH = 16;
	localparam int VAL_W = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Operation codes.
	localparam logic [1:0] FUNC_INSERT    = 2'd0;
	localparam logic [1:0] FUNC_FRONT     = 2'd1;
	localparam logic [1:0] FUNC_TRANSPOSE = 2'd2;
	localparam logic [1:0] FUNC_VIEW      = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_FRONT    = 3'd2;
	localparam logic [2:0] ST_DUP      = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [1:0]              func;
		logic signed [VAL_W-1:0] value;
	} sol_in_t;

	typedef struct packed {
		logic [2:0]              status;
		logic [3:0]              position;
		logic signed [VAL_W-1:0] entry_value;
		logic                    list_empty;
		logic                    last;
	} sol_out_t;

	// Result of the shared comparator.
	typedef struct packed {
		logic eq;
		logic lt;
	} sol_cmp_t;

endpackage

@@ rtl/sol_cmp.sv @@
// Shared signed comparator used on every search step.
// Depends on sol_pkg for widths and the result struct.
module sol_cmp
	import sol_pkg::*;
(
	input  logic signed [VAL_W-1:0] a,
	input  logic signed [VAL_W-1:0] b,
	output sol_cmp_t                res
);

	// Equality and signed less-than of the search key against one entry.
	always_comb begin
		res.eq = (a == b);
		res.lt = (a < b);
	end

endmodule

@@ rtl/sol_store.sv @@
// List storage: one write port and one read port over DEPTH entries.
// Depends on sol_pkg for depth and widths.
module sol_store
	import sol_pkg::*;
(
	input  logic                    clk,
	input  logic                    we,
	input  logic [IDX_W-1:0]        waddr,
	input  logic signed [VAL_W-1:0] wdata,
	input  logic [IDX_W-1:0]        raddr,
	output logic signed [VAL_W-1:0] rdata
);

	logic signed [VAL_W-1:0] mem_q [DEPTH];

	// Entries hold no reset value; only entries below the fill count are read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Single read port.
	assign rdata = mem_q[raddr];

endmodule

@@ rtl/self_organizing_list_unit.sv @@
// Top level of the self-organizing list unit: sequencer, comparator and list store.
// Depends on sol_pkg, sol_cmp and sol_store.
//
// A command is taken when start is high and busy is low; busy then stays high
// until the whole list has been streamed out. A command first searches the
// entries held before it with the single comparator, which looks at one entry
// per cycle, and then decides. When the list changes, entries are shifted up
// through the one read and one write port of the list store, and then the new
// or moved entry is written. Last comes one result per entry held after the
// command, or one result for an empty list. Results appear on rsp with strobe
// high for exactly one cycle each, on consecutive cycles, position 0 first; the
// receiver cannot stall them, and the last one is marked by rsp.last and
// coincides with busy falling.
module self_organizing_list_unit
	import sol_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sol_in_t  req,
	output logic     strobe,
	output sol_out_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_SHIFT,
		S_WRITE,
		S_EMIT
	} state_t;

	state_t                  state_q;
	logic [1:0]              func_q;
	logic signed [VAL_W-1:0] value_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    found_q;
	logic [IDX_W-1:0]        fpos_q;
	logic                    ipos_set_q;
	logic [CNT_W-1:0]        ipos_q;
	logic [IDX_W-1:0]        hi_q;
	logic [IDX_W-1:0]        lo_q;
	logic [2:0]              status_q;
	logic                    strobe_q;
	sol_out_t                rsp_q;

	logic                    we;
	logic [IDX_W-1:0]        waddr;
	logic signed [VAL_W-1:0] wdata;
	logic [IDX_W-1:0]        raddr;
	logic signed [VAL_W-1:0] rdata;
	sol_cmp_t                cmp;

	sol_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	sol_cmp u_cmp (
		.a   (value_q),
		.b   (rdata),
		.res (cmp)
	);

	// Store port steering per sequencer state.
	always_comb begin
		we    = 1'b0;
		waddr = hi_q;
		wdata = rdata;
		raddr = idx_q[IDX_W-1:0];
		case (state_q)
			S_SHIFT: begin
				raddr = IDX_W'(hi_q - 1'b1);
				we    = (hi_q != lo_q);
			end
			S_WRITE: begin
				we    = 1'b1;
				waddr = lo_q;
				wdata = value_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Sequencer with registered result outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			found_q    <= 1'b0;
			ipos_set_q <= 1'b0;
			strobe_q   <= 1'b0;
			func_q     <= FUNC_VIEW;
			status_q   <= ST_OK;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q     <= req.func;
						value_q    <= req.value;
						idx_q      <= '0;
						found_q    <= 1'b0;
						ipos_set_q <= 1'b0;
						ipos_q     <= count_q;
						state_q    <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (idx_q == count_q) begin
						state_q <= S_DECIDE;
					end else begin
						// First match and first entry not below the key.
						if (cmp.eq && !found_q) begin
							found_q <= 1'b1;
							fpos_q  <= idx_q[IDX_W-1:0];
						end
						if ((cmp.eq || cmp.lt) && !ipos_set_q) begin
							ipos_set_q <= 1'b1;
							ipos_q     <= idx_q;
						end
						idx_q <= CNT_W'(idx_q + 1'b1);
					end
				end
				S_DECIDE: begin
					idx_q    <= '0;
					status_q <= ST_OK;
					state_q  <= S_EMIT;
					case (func_q)
						FUNC_INSERT: begin
							if (found_q) begin
								status_q <= ST_DUP;
							end else if (count_q == CNT_W'(DEPTH)) begin
								status_q <= ST_FULL;
							end else begin
								hi_q    <= count_q[IDX_W-1:0];
								lo_q    <= ipos_q[IDX_W-1:0];
								state_q <= S_SHIFT;
							end
						end
						FUNC_FRONT: begin
							if (!found_q) begin
								status_q <= ST_NOTFOUND;
							end else begin
								hi_q    <= fpos_q;
								lo_q    <= '0;
								state_q <= S_SHIFT;
							end
						end
						FUNC_TRANSPOSE: begin
							if (!found_q) begin
								status_q <= ST_NOTFOUND;
							end else if (fpos_q == '0) begin
								status_q <= ST_FRONT;
							end else begin
								hi_q    <= fpos_q;
								lo_q    <= IDX_W'(fpos_q - 1'b1);
								state_q <= S_SHIFT;
							end
						end
						default: begin
							status_q <= ST_OK;
						end
					endcase
				end
				S_SHIFT: begin
					// Move one entry up per cycle until the target slot is open.
					if (hi_q == lo_q) begin
						state_q <= S_WRITE;
					end else begin
						hi_q <= IDX_W'(hi_q - 1'b1);
					end
				end
				S_WRITE: begin
					if (func_q == FUNC_INSERT) begin
						count_q <= CNT_W'(count_q + 1'b1);
					end
					idx_q   <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					strobe_q        <= 1'b1;
					rsp_q.status    <= status_q;
					rsp_q.position  <= 4'(idx_q);
					if (count_q == '0) begin
						rsp_q.entry_value <= '0;
						rsp_q.list_empty  <= 1'b1;
						rsp_q.last        <= 1'b1;
						state_q           <= S_IDLE;
					end else begin
						rsp_q.entry_value <= rdata;
						rsp_q.list_empty  <= 1'b0;
						rsp_q.last        <= (CNT_W'(idx_q + 1'b1) == count_q);
						if (CNT_W'(idx_q + 1'b1) == count_q) begin
							state_q <= S_IDLE;
						end
						idx_q <= CNT_W'(idx_q + 1'b1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

endmodule

@@ rtl/sol_checker.sv @@
// Port-level checker for the self-organizing list unit, bound to the top level.
// Depends on sol_pkg and self_organizing_list_unit_macros.svh.
`include "self_organizing_list_unit_macros.svh"

module sol_checker
	import sol_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input sol_in_t  req,
	input logic     strobe,
	input sol_out_t rsp
);

	// A taken command keeps the block busy in the next cycle.
	`SOL_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "command not taken")

	// Results of one command stream without gaps, positions counting up.
	`SOL_ASSERT_NEXT(a_stream, clk, arst_n, strobe && !rsp.last, strobe && (rsp.position == 4'($past(rsp.position) + 4'd1)) && (rsp.status == $past(rsp.status)), "result stream broken")

	// The block goes idle exactly with the final transfer.
	`SOL_ASSERT_NOW(a_end, clk, arst_n, $fell(busy), strobe && rsp.last, "busy fell without final transfer")

	// An empty list gives one zeroed, final transfer.
	`SOL_ASSERT_NOW(a_empty, clk, arst_n, strobe && rsp.list_empty, rsp.last && (rsp.position == 4'd0) && (rsp.entry_value == '0), "malformed empty-list transfer")

endmodule

bind self_organizing_list_unit sol_checker u_sol_checker (.*);

@@ bench/testbench.sv @@
// Self-checking testbench for the self-organizing list unit.
// It predicts every streamed list entry and compares it against the strobed results.
// Depends on sol_pkg and the self_organizing_list_unit RTL.
`timescale 1ns / 1ps

module testbench;
	import sol_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	sol_in_t  req;
	logic     strobe;
	sol_out_t rsp;

	// Predicted list contents and the list entries still due from the block.
	logic signed [VAL_W-1:0] list_vals [DEPTH];
	int                      list_len;
	sol_out_t                listing_q [$];

	int error_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;

	self_organizing_list_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.rsp    (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic bit in_list(logic signed [VAL_W-1:0] v);
		for (int i = 0; i < list_len; i++)
			if (list_vals[i] == v)
				return 1'b1;
		return 1'b0;
	endfunction

	// Applies one command to the predicted list and returns its status.
	function automatic logic [2:0] apply_cmd(logic [1:0] f, logic signed [VAL_W-1:0] v);
		int                      hit;
		int                      p;
		logic signed [VAL_W-1:0] t;
		logic [2:0]              st;
		hit = -1;
		st = ST_OK;
		for (int i = 0; i < list_len; i++)
			if (hit < 0 && list_vals[i] == v)
				hit = i;
		case (f)
			FUNC_INSERT: begin
				if (hit >= 0) begin
					st = ST_DUP;
				end else if (list_len >= DEPTH) begin
					st = ST_FULL;
				end else begin
					// The new value goes in front of the first larger entry.
					p = 0;
					while (p < list_len && v > list_vals[p])
						p++;
					for (int i = list_len; i > p; i--)
						list_vals[i] = list_vals[i-1];
					list_vals[p] = v;
					list_len++;
				end
			end
			FUNC_FRONT: begin
				if (hit < 0) begin
					st = ST_NOTFOUND;
				end else begin
					t = list_vals[hit];
					for (int i = hit; i > 0; i--)
						list_vals[i] = list_vals[i-1];
					list_vals[0] = t;
				end
			end
			FUNC_TRANSPOSE: begin
				if (hit < 0) begin
					st = ST_NOTFOUND;
				end else if (hit == 0) begin
					st = ST_FRONT;
				end else begin
					t = list_vals[hit];
					list_vals[hit] = list_vals[hit-1];
					list_vals[hit-1] = t;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
		return st;
	endfunction

	// Queues the full listing that follows one command.
	function automatic void queue_listing(logic [2:0] st);
		if (list_len == 0) begin
			listing_q.push_back('{status: st, position: 4'd0, entry_value: '0,
				list_empty: 1'b1, last: 1'b1});
		end else begin
			for (int i = 0; i < list_len; i++)
				listing_q.push_back('{status: st, position: 4'(i), entry_value: list_vals[i],
					list_empty: 1'b0, last: (i == list_len - 1)});
		end
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		if (list_len > 0 && $urandom_range(99) < 60)
			return list_vals[$urandom_range(list_len - 1)];
		return VAL_W'($urandom);
	endfunction

	function automatic logic signed [VAL_W-1:0] fresh_value();
		logic signed [VAL_W-1:0] v;
		v = VAL_W'($urandom);
		while (in_list(v))
			v = VAL_W'($urandom);
		return v;
	endfunction

	// Sends one command and waits for its transfer; start stays high afterwards
	// so that a following command can go out without a gap.
	task automatic send_cmd(input logic [1:0] f, input logic signed [VAL_W-1:0] v);
		int      gap;
		sol_in_t item;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < sender_idle_pct)
			gap++;
		item.func = f;
		item.value = v;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy);
		queue_listing(apply_cmd(f, v));
	endtask

	// Holds off the sender until every predicted entry has come back.
	task automatic wait_list_drained();
		start <= 1'b0;
		while (listing_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic note_error(input string what, input sol_out_t want, input sol_out_t got);
		error_count++;
		if (error_count <= 10) begin
			$display("%0t: %s: expected status %0d pos %0d value %0d empty %0b last %0b",
				$realtime, what, want.status, want.position, want.entry_value,
				want.list_empty, want.last);
			$display("%0t: %s: got status %0d pos %0d value %0d empty %0b last %0b",
				$realtime, what, got.status, got.position, got.entry_value,
				got.list_empty, got.last);
		end
	endtask

	// Every strobed result is compared with the oldest predicted entry.
	always @(posedge clk) begin : rsp_check
		sol_out_t want;
		if (arst_n && strobe) begin
			if (listing_q.size() == 0) begin
				note_error("unexpected result", '0, rsp);
			end else begin
				want = listing_q.pop_front();
				if (rsp.status !== want.status || rsp.position !== want.position ||
					rsp.entry_value !== want.entry_value ||
					rsp.list_empty !== want.list_empty || rsp.last !== want.last)
					note_error("result mismatch", want, rsp);
			end
		end
	end

	// View, move to front and transpose while the list is still empty.
	task automatic test_empty_list();
		send_cmd(FUNC_VIEW, 16'sd0);
		send_cmd(FUNC_FRONT, 16'sd5);
		send_cmd(FUNC_TRANSPOSE, 16'sd5);
	endtask

	// Sorted insert with the extreme values and a duplicate.
	task automatic test_sorted_insert();
		send_cmd(FUNC_INSERT, 16'sd0);
		send_cmd(FUNC_INSERT, 16'sh7FFF);
		send_cmd(FUNC_INSERT, 16'sh8000);
		send_cmd(FUNC_INSERT, -16'sd1);
		send_cmd(FUNC_INSERT, 16'sd0);
	endtask

	// Reordering: entries at the front, misses, and real moves.
	task automatic test_reorder();
		send_cmd(FUNC_TRANSPOSE, 16'sh8000);
		send_cmd(FUNC_FRONT, 16'sh8000);
		send_cmd(FUNC_FRONT, 16'sh7FFF);
		send_cmd(FUNC_TRANSPOSE, 16'sd0);
		send_cmd(FUNC_TRANSPOSE, 16'sd99);
		send_cmd(FUNC_FRONT, 16'sd99);
		send_cmd(FUNC_VIEW, -16'sd1);
	endtask

	// Fill the table, then try a new value and one already held.
	task automatic test_full_table();
		while (list_len < DEPTH)
			send_cmd(FUNC_INSERT, fresh_value());
		send_cmd(FUNC_INSERT, fresh_value());
		send_cmd(FUNC_INSERT, list_vals[$urandom_range(DEPTH - 1)]);
		send_cmd(FUNC_VIEW, 16'sd0);
	endtask

	task automatic test_random_ops(input int n_cmds, input int idle_pct);
		sender_idle_pct = idle_pct;
		for (int i = 0; i < n_cmds; i++)
			send_cmd(2'($urandom_range(3)), pick_value());
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		list_len = 0;
		for (int i = 0; i < DEPTH; i++)
			list_vals[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 14;
		test_empty_list();
		test_sorted_insert();
		test_reorder();
		wait_list_drained();
		test_full_table();
		wait_list_drained();

		test_random_ops(80, 14);
		wait_list_drained();
		test_random_ops(80, 55);
		wait_list_drained();
		test_random_ops(80, 0);

		// Let the last listing arrive, then allow for any stray results.
		wait_list_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && listing_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
